// ===== src/crsd_pkg.sv =====
package crsd_pkg;

  // Linear surface address width; addresses wrap modulo 2**ADDR_BITS (16 to 32).
  localparam int ADDR_BITS = 24;

  localparam int PITCH_W    = 12;
  localparam int WIDTH_W    = 8;
  localparam int ROW_W      = 12;
  localparam int COORD_W    = 12;
  localparam int BYTE_W     = 8;
  localparam int RUN_W      = 7;
  localparam int CFG_DATA_W = 12;
  localparam int CFG_IDX_W  = 2;
  localparam int PROD_W     = PITCH_W + ROW_W;

  localparam logic [PITCH_W-1:0] PITCH_RESET       = PITCH_W'(768);
  localparam logic [WIDTH_W-1:0] WIDTH_RESET       = WIDTH_W'(22);
  localparam logic [ROW_W-1:0]   CLIP_TOP_RESET    = ROW_W'(0);
  localparam logic [ROW_W-1:0]   CLIP_BOTTOM_RESET = ROW_W'(4095);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROW_PITCH    = 2'd0,
    CFG_SPRITE_WIDTH = 2'd1,
    CFG_CLIP_TOP     = 2'd2,
    CFG_CLIP_BOTTOM  = 2'd3
  } cfg_index_t;

  typedef enum logic [1:0] {
    PH_CTRL    = 2'd0,
    PH_LIT     = 2'd1,
    PH_SWALLOW = 2'd2
  } phase_t;

  // Configuration as seen by the decoder, with the clip bounds already
  // turned into addresses.
  typedef struct packed {
    logic [PITCH_W-1:0]   row_pitch;
    logic [WIDTH_W-1:0]   sprite_width;
    logic [ADDR_BITS-1:0] clip_lo;
    logic [ADDR_BITS-1:0] clip_hi;
  } cfg_t;

  // One sprite byte after the input register; base holds start_y * row_pitch.
  typedef struct packed {
    logic [BYTE_W-1:0]    data_byte;
    logic                 letter_start;
    logic [COORD_W-1:0]   start_x;
    logic [ADDR_BITS-1:0] base;
  } item_t;

  // Product reduced or extended to the address width.
  function automatic logic [ADDR_BITS-1:0] fit_addr(input logic [PROD_W-1:0] p);
    logic [ADDR_BITS+PROD_W-1:0] wide;
    wide = {{ADDR_BITS{1'b0}}, p};
    return wide[ADDR_BITS-1:0];
  endfunction

endpackage

// ===== src/crsd_cfg_regs.sv =====
module crsd_cfg_regs (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [crsd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [crsd_pkg::CFG_DATA_W-1:0]   cfg_data,
  output crsd_pkg::cfg_t                    cfg
);

  logic [crsd_pkg::PITCH_W-1:0]   row_pitch, row_pitch_next;
  logic [crsd_pkg::WIDTH_W-1:0]   sprite_width, sprite_width_next;
  logic [crsd_pkg::ROW_W-1:0]     clip_top_row, clip_top_row_next;
  logic [crsd_pkg::ROW_W-1:0]     clip_bottom_row, clip_bottom_row_next;
  logic [crsd_pkg::ADDR_BITS-1:0] clip_lo, clip_hi;
  logic [crsd_pkg::PROD_W-1:0]    lo_prod, hi_prod;

  always_comb begin
    row_pitch_next       = row_pitch;
    sprite_width_next    = sprite_width;
    clip_top_row_next    = clip_top_row;
    clip_bottom_row_next = clip_bottom_row;
    if (cfg_write) begin
      unique case (crsd_pkg::cfg_index_t'(cfg_index))
        crsd_pkg::CFG_ROW_PITCH:    row_pitch_next       = cfg_data[crsd_pkg::PITCH_W-1:0];
        crsd_pkg::CFG_SPRITE_WIDTH: sprite_width_next    = cfg_data[crsd_pkg::WIDTH_W-1:0];
        crsd_pkg::CFG_CLIP_TOP:     clip_top_row_next    = cfg_data[crsd_pkg::ROW_W-1:0];
        crsd_pkg::CFG_CLIP_BOTTOM:  clip_bottom_row_next = cfg_data[crsd_pkg::ROW_W-1:0];
        default: ;
      endcase
    end
  end

  // The bounds follow the register values written in the same cycle, so they
  // are valid as soon as the write has landed.
  assign lo_prod = clip_top_row_next * row_pitch_next;
  assign hi_prod = clip_bottom_row_next * row_pitch_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_pitch       <= crsd_pkg::PITCH_RESET;
      sprite_width    <= crsd_pkg::WIDTH_RESET;
      clip_top_row    <= crsd_pkg::CLIP_TOP_RESET;
      clip_bottom_row <= crsd_pkg::CLIP_BOTTOM_RESET;
      clip_lo         <= crsd_pkg::fit_addr(crsd_pkg::CLIP_TOP_RESET * crsd_pkg::PITCH_RESET);
      clip_hi         <= crsd_pkg::fit_addr(crsd_pkg::CLIP_BOTTOM_RESET * crsd_pkg::PITCH_RESET);
    end else begin
      row_pitch       <= row_pitch_next;
      sprite_width    <= sprite_width_next;
      clip_top_row    <= clip_top_row_next;
      clip_bottom_row <= clip_bottom_row_next;
      clip_lo         <= crsd_pkg::fit_addr(lo_prod);
      clip_hi         <= crsd_pkg::fit_addr(hi_prod);
    end
  end

  assign cfg.row_pitch    = row_pitch;
  assign cfg.sprite_width = sprite_width;
  assign cfg.clip_lo      = clip_lo;
  assign cfg.clip_hi      = clip_hi;

endmodule

// ===== src/crsd_in_stage.sv =====
module crsd_in_stage (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [crsd_pkg::BYTE_W-1:0]       data_byte,
  input  logic                              letter_start,
  input  logic [crsd_pkg::COORD_W-1:0]      start_x,
  input  logic [crsd_pkg::COORD_W-1:0]      start_y,
  input  logic [crsd_pkg::PITCH_W-1:0]      row_pitch,
  input  logic                              s1_take,
  output logic                              s1_valid,
  output crsd_pkg::item_t                   s1_item
);

  logic [crsd_pkg::PROD_W-1:0] row_base;
  logic                        accept;

  assign in_ready = !s1_valid || s1_take;
  assign accept   = in_valid && in_ready;
  assign row_base = start_y * row_pitch;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_take) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item.data_byte    <= data_byte;
      s1_item.letter_start <= letter_start;
      s1_item.start_x      <= start_x;
      s1_item.base         <= crsd_pkg::fit_addr(row_base);
    end
  end

endmodule

// ===== src/crsd_core.sv =====
module crsd_core (
  input  logic                               clk,
  input  logic                               rst,
  input  crsd_pkg::cfg_t                     cfg,
  input  logic                               s1_valid,
  input  crsd_pkg::item_t                    s1_item,
  output logic                               s1_take,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [crsd_pkg::ADDR_BITS-1:0]     pixel_address,
  output logic [crsd_pkg::BYTE_W-1:0]        pixel_value
);

  localparam int AW = crsd_pkg::ADDR_BITS;

  crsd_pkg::phase_t             phase, phase_next;
  logic [crsd_pkg::RUN_W-1:0]   run_remaining, run_remaining_next;
  logic [AW-1:0]                write_address, write_address_next;
  logic [crsd_pkg::WIDTH_W-1:0] row_pixels_left, row_pixels_left_next;
  logic                         emit;

  // Values after the optional start load.
  crsd_pkg::phase_t             ph0;
  logic [crsd_pkg::RUN_W-1:0]   rr0;
  logic [AW-1:0]                a0;
  logic [crsd_pkg::WIDTH_W-1:0] rpl0;

  logic [crsd_pkg::BYTE_W-1:0]  ctrl;
  logic [crsd_pkg::BYTE_W-1:0]  step_n;
  logic [AW-1:0]                a_adv, a_row;
  logic                         row_end;
  logic                         clipped;
  logic [crsd_pkg::RUN_W-1:0]   rr_dec;

  assign s1_take = s1_valid && (!out_valid || out_ready);
  assign ctrl    = s1_item.data_byte;

  always_comb begin
    if (s1_item.letter_start) begin
      a0   = s1_item.base + {{(AW-crsd_pkg::COORD_W){1'b0}}, s1_item.start_x};
      rpl0 = cfg.sprite_width;
      ph0  = crsd_pkg::PH_CTRL;
      rr0  = '0;
    end else begin
      a0   = write_address;
      rpl0 = row_pixels_left;
      ph0  = phase;
      rr0  = run_remaining;
    end
  end

  // A literal pixel steps by one; a negative control skips its magnitude;
  // a clipped positive control skips the whole run.
  always_comb begin
    if (ph0 == crsd_pkg::PH_LIT) begin
      step_n = crsd_pkg::BYTE_W'(1);
    end else if (ctrl[crsd_pkg::BYTE_W-1]) begin
      step_n = -ctrl;
    end else begin
      step_n = ctrl;
    end
  end

  assign a_adv   = a0 + {{(AW-crsd_pkg::BYTE_W){1'b0}}, step_n};
  assign a_row   = a_adv - {{(AW-crsd_pkg::PITCH_W){1'b0}}, cfg.row_pitch}
                         - {{(AW-crsd_pkg::WIDTH_W){1'b0}}, cfg.sprite_width};
  assign row_end = (step_n >= rpl0);
  assign clipped = (a0 < cfg.clip_lo) || (a0 > cfg.clip_hi);
  assign rr_dec  = rr0 - crsd_pkg::RUN_W'(1);

  always_comb begin
    phase_next           = ph0;
    run_remaining_next   = rr0;
    write_address_next   = a0;
    row_pixels_left_next = rpl0;
    emit                 = 1'b0;
    unique case (ph0)
      crsd_pkg::PH_LIT: begin
        emit               = 1'b1;
        run_remaining_next = rr_dec;
        if (rr_dec == '0) begin
          phase_next = crsd_pkg::PH_CTRL;
        end
        write_address_next   = row_end ? a_row : a_adv;
        row_pixels_left_next = row_end ? cfg.sprite_width : rpl0 - step_n;
      end
      crsd_pkg::PH_SWALLOW: begin
        run_remaining_next = rr_dec;
        if (rr_dec == '0) begin
          phase_next = crsd_pkg::PH_CTRL;
        end
      end
      crsd_pkg::PH_CTRL: begin
        if (ctrl[crsd_pkg::BYTE_W-1]) begin
          write_address_next   = row_end ? a_row : a_adv;
          row_pixels_left_next = row_end ? cfg.sprite_width : rpl0 - step_n;
        end else if (ctrl != '0) begin
          run_remaining_next = ctrl[crsd_pkg::RUN_W-1:0];
          if (clipped) begin
            phase_next           = crsd_pkg::PH_SWALLOW;
            write_address_next   = row_end ? a_row : a_adv;
            row_pixels_left_next = row_end ? cfg.sprite_width : rpl0 - step_n;
          end else begin
            phase_next = crsd_pkg::PH_LIT;
          end
        end
      end
      default: begin
        phase_next = crsd_pkg::PH_CTRL;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= crsd_pkg::PH_CTRL;
      run_remaining   <= '0;
      write_address   <= '0;
      row_pixels_left <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (s1_take) begin
        phase           <= phase_next;
        run_remaining   <= run_remaining_next;
        write_address   <= write_address_next;
        row_pixels_left <= row_pixels_left_next;
        out_valid       <= emit;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take && emit) begin
      pixel_address <= a0;
      pixel_value   <= ctrl;
    end
  end

endmodule

// ===== src/clipped_rle_sprite_decoder_unit.sv =====
// Transparent run-length sprite decoder with a row clip window. Each input
// transfer carries one sprite byte; a byte with letter_start set begins a new
// sprite at start_y * row_pitch + start_x and is read as a control byte.
// Negative controls skip pixels, a positive control n announces n literal
// pixels, each of which leaves as one output transfer (pixel_address,
// pixel_value); control bytes and swallowed pixels give no output. A run whose
// control byte finds the address outside the clip window is swallowed and the
// address advances as for a skip. The block takes one byte per clock cycle
// while its results are taken; a byte passes through the input register and
// then the decode stage into the output register: start_y * row_pitch is
// formed on the way into the input register, and when the decode stage
// takes the byte it updates the address, row count and run state and loads
// the output register. When the output register holds a result that is not
// taken, the decode stage waits and in_ready falls once the input register
// is full as well. Configuration writes take effect at once and must only be
// made while no byte is in flight.
module clipped_rle_sprite_decoder_unit (
  input  logic                              clk,
  input  logic                              rst,
  // Configuration write port
  input  logic                              cfg_write,
  input  logic [crsd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [crsd_pkg::CFG_DATA_W-1:0]   cfg_data,
  // Sprite byte channel
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [crsd_pkg::BYTE_W-1:0]       data_byte,
  input  logic                              letter_start,
  input  logic [crsd_pkg::COORD_W-1:0]      start_x,
  input  logic [crsd_pkg::COORD_W-1:0]      start_y,
  // Pixel write channel
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [crsd_pkg::ADDR_BITS-1:0]    pixel_address,
  output logic [crsd_pkg::BYTE_W-1:0]       pixel_value
);

  crsd_pkg::cfg_t  cfg;
  crsd_pkg::item_t s1_item;
  logic            s1_valid;
  logic            s1_take;

  // Register file; the clip bounds are kept as ready-made addresses so the
  // decode stage only compares.
  crsd_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Input register; it frees itself whenever the decode stage takes its byte.
  crsd_in_stage u_in (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .data_byte    (data_byte),
    .letter_start (letter_start),
    .start_x      (start_x),
    .start_y      (start_y),
    .row_pitch    (cfg.row_pitch),
    .s1_take      (s1_take),
    .s1_valid     (s1_valid),
    .s1_item      (s1_item)
  );

  // Decode stage holding the sprite state and the output register.
  crsd_core u_core (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .s1_valid      (s1_valid),
    .s1_item       (s1_item),
    .s1_take       (s1_take),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .pixel_address (pixel_address),
    .pixel_value   (pixel_value)
  );

endmodule

// ===== src/crsd_checker.sv =====
module crsd_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [crsd_pkg::ADDR_BITS-1:0] pixel_address,
  input logic [crsd_pkg::BYTE_W-1:0]    pixel_value
);

  // A result that is not taken stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(pixel_address) && $stable(pixel_value))
    else $error("pixel write changed while stalled");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result present after reset");

  // With the output register empty the decode stage drains the input register,
  // so a new byte can always be taken.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with an empty output register");

endmodule

bind clipped_rle_sprite_decoder_unit crsd_checker u_crsd_checker (
  .clk           (clk),
  .rst           (rst),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .pixel_address (pixel_address),
  .pixel_value   (pixel_value)
);
